/* sv/v4m44_pkg.sv */
// ----------------------------------------------------------------------------
// v4m44_pkg - shared types and constants of the vertex transform unit
// Beat layout, fixed-point constants and width helpers used by all files.
// ----------------------------------------------------------------------------
package v4m44_pkg;

   // component width of every vector and result field
   localparam int DATA_W = 32;
   // matrix is 4x4: four lanes, two index bits per axis
   localparam int NUM_LANES = 4;
   localparam int LANE_W = 2;
   localparam int IDX_W = 2 * LANE_W;

   // defaults of the top-level parameters
   localparam int COEF_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   typedef logic signed [DATA_W-1:0] comp_type;
   typedef comp_type [NUM_LANES-1:0] vec_type;

   localparam comp_type COMP_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam comp_type COMP_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   // one beat as it travels down the cell chain
   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   coef_index;
      comp_type           coef_value;
      vec_type            vec;
   } beat_type;

   // stored coefficient width: the load field carries at most DATA_W bits
   function automatic int store_width(input int coef_width);
      return (coef_width < DATA_W) ? coef_width : DATA_W;
   endfunction

   // accumulator width: one full product plus two bits of growth for four terms
   function automatic int acc_width(input int coef_width);
      return DATA_W + store_width(coef_width) + LANE_W;
   endfunction

endpackage

/* sv/v4m44_if.sv */
// ----------------------------------------------------------------------------
// v4m44 channel interfaces
// Valid/ready channels for request beats and transform results.
// ----------------------------------------------------------------------------
interface v4m44_req_if;
   logic                 valid;
   logic                 ready;
   v4m44_pkg::op_type    op;
   logic [3:0]           coef_index;
   v4m44_pkg::comp_type  coef_value;
   v4m44_pkg::comp_type  vec_x;
   v4m44_pkg::comp_type  vec_y;
   v4m44_pkg::comp_type  vec_z;
   v4m44_pkg::comp_type  vec_w;

   modport source (output valid, op, coef_index, coef_value, vec_x, vec_y, vec_z, vec_w,
                   input ready);
   modport sink   (input valid, op, coef_index, coef_value, vec_x, vec_y, vec_z, vec_w,
                   output ready);
endinterface

interface v4m44_rsp_if;
   logic                 valid;
   logic                 ready;
   v4m44_pkg::comp_type  out_x;
   v4m44_pkg::comp_type  out_y;
   v4m44_pkg::comp_type  out_z;
   v4m44_pkg::comp_type  out_w;
   logic                 saturated;

   modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

/* sv/vec4_matrix4x4_transform.sv */
// ----------------------------------------------------------------------------
// vec4_matrix4x4_transform - 4x4 matrix by 4-vector transform, Q16.16
// Four column cells hold the matrix and accumulate the products of one
// vector per beat; a final stage scales and saturates the four sums.
//
//   channel   | direction | contents
//   ----------+-----------+-------------------------------------------------
//   req_chan  | in        | op, coef_index, coef_value, vec_x..vec_w
//   rsp_chan  | out       | out_x..out_w, saturated (transform beats only)
//   csr_*     | in        | column_major layout bit, write enable and data
//
// One beat is accepted per cycle while the chain is not stalled; a transform
// result passes two register stages in each cell, then one output register.
// Load beats travel the same chain and update each cell as they pass, so
// later transforms see them in order; they produce no result.
// Reset clears the valid bits and column_major; coefficients are undefined
// until loaded. Back-pressure from rsp_chan stalls only full stages, so
// empty stages in the chain keep filling while a result waits.
// ----------------------------------------------------------------------------
module vec4_matrix4x4_transform #(
   parameter int COEF_WIDTH = v4m44_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS = v4m44_pkg::FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   v4m44_req_if.sink      req_chan,
   v4m44_rsp_if.source    rsp_chan,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data
);

   localparam int ACC_W = v4m44_pkg::acc_width(COEF_WIDTH);
   localparam int LANES = v4m44_pkg::NUM_LANES;

   logic                     column_major_ff;
   logic                     valid_chain [LANES+1];
   logic                     ready_chain [LANES+1];
   v4m44_pkg::beat_type      beat_chain  [LANES+1];
   logic signed [ACC_W-1:0]  acc_chain   [LANES+1][LANES];

   // layout register
   always_ff @(posedge clock) begin
      if (reset) begin
         column_major_ff <= 1'b0;
      end else if (csr_wr_en) begin
         column_major_ff <= csr_wr_data;
      end
   end

   // pack the request into the head beat; sums start at zero
   always_comb begin
      beat_chain[0].op         = req_chan.op;
      beat_chain[0].coef_index = req_chan.coef_index;
      beat_chain[0].coef_value = req_chan.coef_value;
      beat_chain[0].vec        = {req_chan.vec_w, req_chan.vec_z,
                                  req_chan.vec_y, req_chan.vec_x};
      for (int r = 0; r < LANES; r++) begin
         acc_chain[0][r] = '0;
      end
   end

   assign valid_chain[0] = req_chan.valid;
   assign req_chan.ready = ready_chain[0];

   // one cell per vector component
   for (genvar c = 0; c < LANES; c++) begin : g_cell
      v4m44_cell #(
         .COEF_WIDTH (COEF_WIDTH),
         .CELL_COL   (c)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .column_major (column_major_ff),
         .in_valid     (valid_chain[c]),
         .in_ready     (ready_chain[c]),
         .in_beat      (beat_chain[c]),
         .in_acc       (acc_chain[c]),
         .out_valid    (valid_chain[c+1]),
         .out_ready    (ready_chain[c+1]),
         .out_beat     (beat_chain[c+1]),
         .out_acc      (acc_chain[c+1])
      );
   end

   // scale, saturate and present the result
   v4m44_sat #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_sat (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_chain[LANES]),
      .in_ready (ready_chain[LANES]),
      .in_op    (beat_chain[LANES].op),
      .in_acc   (acc_chain[LANES]),
      .rsp_chan (rsp_chan)
   );

endmodule

/* sv/v4m44_cell.sv */
// ----------------------------------------------------------------------------
// v4m44_cell - one column cell of the transform chain
// Holds the coefficients that weight vector component CELL_COL, multiplies
// that component by them and adds the products into the passing sums.
// ----------------------------------------------------------------------------
module v4m44_cell #(
   parameter int COEF_WIDTH = v4m44_pkg::COEF_WIDTH_DEF,
   parameter int CELL_COL = 0,
   localparam int ACC_W = v4m44_pkg::acc_width(COEF_WIDTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        column_major,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  v4m44_pkg::beat_type         in_beat,
   input  logic signed [ACC_W-1:0]     in_acc [v4m44_pkg::NUM_LANES],
   output logic                        out_valid,
   input  logic                        out_ready,
   output v4m44_pkg::beat_type         out_beat,
   output logic signed [ACC_W-1:0]     out_acc [v4m44_pkg::NUM_LANES]
);

   localparam int STORE_W = v4m44_pkg::store_width(COEF_WIDTH);
   localparam int PROD_W = v4m44_pkg::DATA_W + STORE_W;
   localparam int LANES = v4m44_pkg::NUM_LANES;
   localparam int LW = v4m44_pkg::LANE_W;
   localparam logic [LW-1:0] CELL_ID = LW'(CELL_COL);

   // row_coef_ff[r] is entry 4r+CELL_COL, col_coef_ff[r] is entry 4*CELL_COL+r
   logic signed [STORE_W-1:0] row_coef_ff [LANES];
   logic signed [STORE_W-1:0] col_coef_ff [LANES];
   logic signed [STORE_W-1:0] coef_sel    [LANES];
   logic signed [v4m44_pkg::DATA_W-1:0] vec_c;
   logic signed [PROD_W-1:0]  prod_in [LANES];
   logic signed [PROD_W-1:0]  prod_ff [LANES];
   logic signed [ACC_W-1:0]   s1_acc_ff [LANES];
   logic signed [ACC_W-1:0]   s2_acc_in [LANES];
   logic signed [ACC_W-1:0]   s2_acc_ff [LANES];
   v4m44_pkg::beat_type       s1_beat_ff;
   v4m44_pkg::beat_type       s2_beat_ff;
   logic                      s1_valid_ff;
   logic                      s2_valid_ff;
   logic                      s1_take;
   logic                      s2_take;
   logic                      load_en;

   // advance each stage when it is empty or its contents move on
   assign s2_take  = !s2_valid_ff || out_ready;
   assign s1_take  = !s1_valid_ff || s2_take;
   assign in_ready = s1_take;
   assign load_en  = in_valid && s1_take && (in_beat.op == v4m44_pkg::OP_LOAD);

   // multiply this cell's component by the coefficients of the active layout
   always_comb begin
      vec_c = in_beat.vec[CELL_COL];
      for (int r = 0; r < LANES; r++) begin
         coef_sel[r] = column_major ? col_coef_ff[r] : row_coef_ff[r];
         prod_in[r]  = PROD_W'(vec_c) * PROD_W'(coef_sel[r]);
      end
   end

   // add products into the passing partial sums
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         s2_acc_in[r] = s1_acc_ff[r] + ACC_W'(prod_ff[r]);
      end
   end

   // write a load beat into this cell as it passes
   always_ff @(posedge clock) begin
      if (load_en && (in_beat.coef_index[LW-1:0] == CELL_ID)) begin
         row_coef_ff[in_beat.coef_index[2*LW-1:LW]] <= in_beat.coef_value[STORE_W-1:0];
      end
      if (load_en && (in_beat.coef_index[2*LW-1:LW] == CELL_ID)) begin
         col_coef_ff[in_beat.coef_index[LW-1:0]] <= in_beat.coef_value[STORE_W-1:0];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_beat_ff <= in_beat;
         s1_acc_ff  <= in_acc;
         prod_ff    <= prod_in;
      end
      if (s2_take) begin
         s2_beat_ff <= s1_beat_ff;
         s2_acc_ff  <= s2_acc_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_beat  = s2_beat_ff;
   assign out_acc   = s2_acc_ff;

endmodule

/* sv/v4m44_sat.sv */
// ----------------------------------------------------------------------------
// v4m44_sat - scale, saturate and register the transform result
// Shifts the four sums down by FRAC_BITS, clips them to 32 bits, drops
// load beats and holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module v4m44_sat #(
   parameter int COEF_WIDTH = v4m44_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS = v4m44_pkg::FRAC_BITS_DEF,
   localparam int ACC_W = v4m44_pkg::acc_width(COEF_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  v4m44_pkg::op_type         in_op,
   input  logic signed [ACC_W-1:0]   in_acc [v4m44_pkg::NUM_LANES],
   v4m44_rsp_if.source               rsp_chan
);

   localparam int LANES = v4m44_pkg::NUM_LANES;
   localparam int DW = v4m44_pkg::DATA_W;

   logic signed [ACC_W-1:0]  shifted  [LANES];
   logic [LANES-1:0]         clip;
   v4m44_pkg::comp_type      comp_in  [LANES];
   v4m44_pkg::comp_type      comp_ff  [LANES];
   logic                     sat_ff;
   logic                     valid_ff;
   logic                     take;

   assign take     = !valid_ff || rsp_chan.ready;
   assign in_ready = take;

   // scale down, rounding toward minus infinity, then clip to the 32-bit range
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         shifted[r] = in_acc[r] >>> FRAC_BITS;
         clip[r] = !((&shifted[r][ACC_W-1:DW-1]) || !(|shifted[r][ACC_W-1:DW-1]));
         if (!clip[r]) begin
            comp_in[r] = shifted[r][DW-1:0];
         end else if (shifted[r][ACC_W-1]) begin
            comp_in[r] = v4m44_pkg::COMP_MIN;
         end else begin
            comp_in[r] = v4m44_pkg::COMP_MAX;
         end
      end
   end

   // result valid: only transform beats produce a result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid && (in_op == v4m44_pkg::OP_XFORM);
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      if (take) begin
         comp_ff <= comp_in;
         sat_ff  <= |clip;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_x     = comp_ff[0];
   assign rsp_chan.out_y     = comp_ff[1];
   assign rsp_chan.out_z     = comp_ff[2];
   assign rsp_chan.out_w     = comp_ff[3];
   assign rsp_chan.saturated = sat_ff;

endmodule

/* tb/vec4_matrix4x4_transform_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec4_matrix4x4_transform_test - self-checking bench for the vertex transform
// Loads the coefficient matrix, then streams load and transform beats under
// random valid and ready gaps, at full rate in the last stretch. Expected
// vectors come from a Q16.16 matrix-vector model kept in step with every
// accepted beat. Both row-major and column-major layouts are covered, and so
// is saturation in both directions.
// ----------------------------------------------------------------------------
module vec4_matrix4x4_transform_test;

   // depth of the cell chain and output register, plus margin for load beats in flight
   localparam int CHAIN_FLUSH = 9 + 4;
   localparam int STALL_LIMIT = 1000;

   typedef struct {
      v4m44_pkg::op_type    op;
      logic [3:0]           coef_index;
      v4m44_pkg::comp_type  coef_value;
      v4m44_pkg::comp_type  vec_x;
      v4m44_pkg::comp_type  vec_y;
      v4m44_pkg::comp_type  vec_z;
      v4m44_pkg::comp_type  vec_w;
   } req_beat_type;

   typedef struct {
      v4m44_pkg::comp_type  out_x;
      v4m44_pkg::comp_type  out_y;
      v4m44_pkg::comp_type  out_z;
      v4m44_pkg::comp_type  out_w;
      logic                 saturated;
   } xform_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   v4m44_req_if req_bus ();
   v4m44_rsp_if rsp_bus ();

   vec4_matrix4x4_transform uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // model state: coefficient mirror and layout bit
   v4m44_pkg::comp_type  coef_mirror [16];
   logic                 layout_column_major;

   req_beat_type      pending_beats [$];
   xform_result_type  expected_xforms [$];
   req_beat_type      next_beat;
   xform_result_type  got_xform;
   xform_result_type  want_xform;
   int                beats_queued;
   int                beats_accepted = 0;
   int                mismatch_count = 0;
   int                send_gap = 0;
   int                stall_left = 0;
   int                quiet_cycles = 0;
   bit                idling_on;

   always #1 clock = ~clock;

   // Q16.16 matrix times vector: exact sums, arithmetic shift, clip to 32 bits
   function automatic xform_result_type transform_vector(v4m44_pkg::comp_type x,
                                                         v4m44_pkg::comp_type y,
                                                         v4m44_pkg::comp_type z,
                                                         v4m44_pkg::comp_type w);
      v4m44_pkg::comp_type  vec_in [4];
      v4m44_pkg::comp_type  lane_out [4];
      logic signed [65:0]   acc;
      logic signed [65:0]   scaled;
      longint               prod;
      int                   idx;
      xform_result_type     res;
      vec_in[0] = x;
      vec_in[1] = y;
      vec_in[2] = z;
      vec_in[3] = w;
      res.saturated = 1'b0;
      for (int r = 0; r < 4; r++) begin
         acc = '0;
         for (int c = 0; c < 4; c++) begin
            idx = layout_column_major ? (c * 4 + r) : (r * 4 + c);
            prod = longint'(vec_in[c]) * longint'(coef_mirror[idx]);
            acc = acc + prod;
         end
         scaled = acc >>> v4m44_pkg::FRAC_BITS_DEF;
         if (scaled > v4m44_pkg::COMP_MAX) begin
            lane_out[r] = v4m44_pkg::COMP_MAX;
            res.saturated = 1'b1;
         end else if (scaled < v4m44_pkg::COMP_MIN) begin
            lane_out[r] = v4m44_pkg::COMP_MIN;
            res.saturated = 1'b1;
         end else begin
            lane_out[r] = v4m44_pkg::comp_type'(scaled);
         end
      end
      res.out_x = lane_out[0];
      res.out_y = lane_out[1];
      res.out_z = lane_out[2];
      res.out_w = lane_out[3];
      return res;
   endfunction

   // mix of extremes, small values that stay in range, and full-range noise
   function automatic v4m44_pkg::comp_type rand_fixed();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      unique case (pick)
         0: return v4m44_pkg::COMP_MAX;
         1: return v4m44_pkg::COMP_MIN;
         2: return '0;
         3: return '1;
         4, 5, 6: return v4m44_pkg::comp_type'(int'($urandom_range(0, 32'h001F_FFFF))
                                               - 32'sh0010_0000);
         default: return v4m44_pkg::comp_type'($urandom);
      endcase
   endfunction

   task automatic push_load(input logic [3:0] idx, input v4m44_pkg::comp_type value);
      req_beat_type b;
      b.op = v4m44_pkg::OP_LOAD;
      b.coef_index = idx;
      b.coef_value = value;
      b.vec_x = $urandom;
      b.vec_y = $urandom;
      b.vec_z = $urandom;
      b.vec_w = $urandom;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic push_xform(input v4m44_pkg::comp_type x, input v4m44_pkg::comp_type y,
                             input v4m44_pkg::comp_type z, input v4m44_pkg::comp_type w);
      req_beat_type b;
      b.op = v4m44_pkg::OP_XFORM;
      b.coef_index = 4'($urandom);
      b.coef_value = $urandom;
      b.vec_x = x;
      b.vec_y = y;
      b.vec_z = z;
      b.vec_w = w;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            push_load(4'($urandom), rand_fixed());
         else
            push_xform(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
      end
   endtask

   // hold off until every beat is in and every result is out, then let the chain empty
   task automatic drain_chain();
      while (!(beats_accepted == beats_queued && expected_xforms.size() == 0))
         @(negedge clock);
      repeat (CHAIN_FLUSH) @(posedge clock);
   endtask

   task automatic write_layout(input logic col_major);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= col_major;
      layout_column_major = col_major;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver: predict on each accepted beat, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.op <= v4m44_pkg::OP_LOAD;
         req_bus.coef_index <= '0;
         req_bus.coef_value <= '0;
         req_bus.vec_x <= '0;
         req_bus.vec_y <= '0;
         req_bus.vec_z <= '0;
         req_bus.vec_w <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            beats_accepted++;
            if (req_bus.op == v4m44_pkg::OP_LOAD)
               coef_mirror[req_bus.coef_index] = req_bus.coef_value;
            else
               expected_xforms.push_back(transform_vector(req_bus.vec_x, req_bus.vec_y,
                                                          req_bus.vec_z, req_bus.vec_w));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               next_beat = pending_beats.pop_front();
               req_bus.op <= next_beat.op;
               req_bus.coef_index <= next_beat.coef_index;
               req_bus.coef_value <= next_beat.coef_value;
               req_bus.vec_x <= next_beat.vec_x;
               req_bus.vec_y <= next_beat.vec_y;
               req_bus.vec_z <= next_beat.vec_z;
               req_bus.vec_w <= next_beat.vec_w;
               req_bus.valid <= 1'b1;
               if (idling_on && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 10);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each beat with the oldest expectation, then pick ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_xform.out_x = rsp_bus.out_x;
         got_xform.out_y = rsp_bus.out_y;
         got_xform.out_z = rsp_bus.out_z;
         got_xform.out_w = rsp_bus.out_w;
         got_xform.saturated = rsp_bus.saturated;
         if (expected_xforms.size() == 0) begin
            $error("result beat with no transform outstanding: x=%0d y=%0d z=%0d w=%0d",
                   got_xform.out_x, got_xform.out_y, got_xform.out_z, got_xform.out_w);
            mismatch_count++;
         end else begin
            want_xform = expected_xforms.pop_front();
            if (got_xform.out_x !== want_xform.out_x) begin
               $error("out_x: expected %0d, got %0d", want_xform.out_x, got_xform.out_x);
               mismatch_count++;
            end
            if (got_xform.out_y !== want_xform.out_y) begin
               $error("out_y: expected %0d, got %0d", want_xform.out_y, got_xform.out_y);
               mismatch_count++;
            end
            if (got_xform.out_z !== want_xform.out_z) begin
               $error("out_z: expected %0d, got %0d", want_xform.out_z, got_xform.out_z);
               mismatch_count++;
            end
            if (got_xform.out_w !== want_xform.out_w) begin
               $error("out_w: expected %0d, got %0d", want_xform.out_w, got_xform.out_w);
               mismatch_count++;
            end
            if (got_xform.saturated !== want_xform.saturated) begin
               $error("saturated: expected %0b, got %0b",
                      want_xform.saturated, got_xform.saturated);
               mismatch_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      layout_column_major = 1'b0;
      beats_queued = 0;
      idling_on = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_layout(1'b0);

      // fill the whole matrix: row 0 all max, row 1 all min, row 2 picks z, row 3 mixed
      for (int i = 0; i < 4; i++)
         push_load(4'(i), v4m44_pkg::COMP_MAX);
      for (int i = 4; i < 8; i++)
         push_load(4'(i), v4m44_pkg::COMP_MIN);
      push_load(4'd8, '0);
      push_load(4'd9, '0);
      push_load(4'd10, v4m44_pkg::comp_type'(32'sh0001_0000));
      push_load(4'd11, '0);
      push_load(4'd12, '1);
      push_load(4'd13, v4m44_pkg::comp_type'(32'sh0000_8000));
      push_load(4'd14, '0);
      push_load(4'd15, v4m44_pkg::comp_type'(32'sh0001_0000));

      // saturate both ways, zero vector, round toward minus infinity, plain values
      push_xform(v4m44_pkg::COMP_MAX, v4m44_pkg::COMP_MAX,
                 v4m44_pkg::COMP_MAX, v4m44_pkg::COMP_MAX);
      push_xform(v4m44_pkg::COMP_MIN, v4m44_pkg::COMP_MIN,
                 v4m44_pkg::COMP_MIN, v4m44_pkg::COMP_MIN);
      push_xform('0, '0, '0, '0);
      push_xform('1, '1, '1, '1);
      push_xform(v4m44_pkg::comp_type'(32'sh0002_0000),
                 v4m44_pkg::comp_type'(-32'sh0000_0003),
                 v4m44_pkg::comp_type'(32'sh0003_8000),
                 v4m44_pkg::comp_type'(-32'sh0001_0000));

      // replace one entry of each saturating row with a small value and transform again
      push_load(4'd0, v4m44_pkg::comp_type'(32'sh0000_4000));
      push_load(4'd5, v4m44_pkg::comp_type'(-32'sh0002_0000));
      push_xform(v4m44_pkg::comp_type'(32'sh0001_0000), v4m44_pkg::comp_type'(32'sh0001_0000),
                 v4m44_pkg::comp_type'(32'sh0001_0000), v4m44_pkg::comp_type'(32'sh0001_0000));
      drain_chain();

      write_layout(1'b1);
      push_xform(v4m44_pkg::COMP_MAX, '0, v4m44_pkg::COMP_MIN, '1);
      push_random(130);
      drain_chain();

      write_layout(1'b0);
      push_random(130);
      drain_chain();

      // last stretch runs at full rate on both sides
      idling_on = 1'b0;
      write_layout(1'b1);
      push_random(140);
      drain_chain();

      if (mismatch_count == 0 && expected_xforms.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
sv/v4m44_pkg.sv
sv/v4m44_if.sv
sv/v4m44_cell.sv
sv/v4m44_sat.sv
sv/vec4_matrix4x4_transform.sv
tb/vec4_matrix4x4_transform_test.sv
